FILE: sv/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg
// Shared types for the sliding window mode filter: the command and status
// groups between the controller and the datapath, and the result width.
// ----------------------------------------------------------------------------
package swmf_pkg;

    localparam int OUT_WIDTH = 32;

    typedef struct packed {
        logic capture;     // latch sample, update window
        logic scan_start;  // clear best, rewind candidate index
        logic step;        // issue next candidate into the count pipeline
        logic load_out;    // load the output register
        logic use_mode;    // output the window mode rather than the sample
    } cmd_t;

    typedef struct packed {
        logic full;        // held count has reached the window size
        logic last;        // candidate index is on the oldest held entry
        logic busy;        // count pipeline still holds candidates
    } status_t;

endpackage

FILE: sv/swmf_ctrl.sv
// ----------------------------------------------------------------------------
// swmf_ctrl
// Controller: takes one request, steers the candidate scan of the datapath
// and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module swmf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output swmf_pkg::cmd_t    cmd,
    input  swmf_pkg::status_t status
);
    import swmf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   mode_reg;
    logic   out_valid_reg;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.use_mode   = mode_reg;
        case (state_reg)
            ST_IDLE:   cmd.capture    = in_valid;
            ST_CHECK:  cmd.scan_start = status.full;
            ST_SCAN:   cmd.step       = 1'b1;
            ST_DRAIN:  cmd.step       = 1'b0;
            ST_FINISH: cmd.load_out   = slot_free;
            default:   cmd            = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result replaces one that leaves in the same cycle
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    mode_reg  <= status.full;
                    state_reg <= status.full ? ST_SCAN : ST_FINISH;
                end
                ST_SCAN:
                begin
                    if (status.last)
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    if (!status.busy)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (slot_free)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/swmf_datapath.sv
// ----------------------------------------------------------------------------
// swmf_datapath
// Sample window as a shift line, a candidate counting pipeline that compares
// one candidate against all held entries at once, the running best and the
// output register.
// ----------------------------------------------------------------------------
module swmf_datapath #(
    parameter int WINDOW       = 20,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [SAMPLE_WIDTH-1:0]          sample,
    input  swmf_pkg::cmd_t                   cmd,
    output swmf_pkg::status_t                status,
    output logic [swmf_pkg::OUT_WIDTH-1:0]   filtered_value,
    output logic                             from_window
);
    import swmf_pkg::*;

    localparam int DEPTH = WINDOW + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    // entry 0 is the newest sample, entry held-1 the oldest
    logic [SAMPLE_WIDTH-1:0] win_reg [DEPTH];
    logic [CW-1:0]           held_reg;
    logic [CW-1:0]           held_next;
    logic [SAMPLE_WIDTH-1:0] sample_reg;
    logic                    positive;

    logic [IW-1:0]           idx_reg;
    logic                    p1_valid_reg;
    logic                    p2_valid_reg;
    logic                    p3_valid_reg;
    logic [SAMPLE_WIDTH-1:0] cand_reg;
    logic [SAMPLE_WIDTH-1:0] cand2_reg;
    logic [SAMPLE_WIDTH-1:0] cand3_reg;
    logic [DEPTH-1:0]        match_reg;
    logic [DEPTH-1:0]        match_next;
    logic [CW-1:0]           cnt_reg;
    logic [CW-1:0]           cnt_next;
    logic [SAMPLE_WIDTH-1:0] best_val_reg;
    logic [CW-1:0]           best_cnt_reg;
    logic                    better;

    logic [OUT_WIDTH-1:0]    filtered_reg;
    logic                    from_window_reg;
    logic [OUT_WIDTH+SAMPLE_WIDTH-1:0] ext_mode;
    logic [OUT_WIDTH+SAMPLE_WIDTH-1:0] ext_pass;

    assign positive = (sample[SAMPLE_WIDTH-1] == 1'b0) && (sample != '0);

    always_comb
    begin
        held_next = held_reg;
        if (held_reg == CW'(DEPTH))
            held_next = CW'(DEPTH - 1);
        if (positive)
            held_next = held_next + CW'(1);
    end

    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
            match_next[j] = (CW'(j) < held_reg) && (win_reg[j] == cand_reg);
    end

    always_comb
    begin
        cnt_next = '0;
        for (int j = 0; j < DEPTH; j++)
            cnt_next = cnt_next + CW'(match_reg[j]);
    end

    // ties go to the smaller value
    assign better = (cnt_reg > best_cnt_reg) ||
                    ((cnt_reg == best_cnt_reg) &&
                     ($signed(cand3_reg) < $signed(best_val_reg)));

    assign status.full = (held_reg >= CW'(WINDOW));
    assign status.last = (CW'(idx_reg) == (held_reg - CW'(1)));
    assign status.busy = p1_valid_reg || p2_valid_reg || p3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= '0;
            idx_reg      <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
                held_reg <= held_next;
            if (cmd.scan_start)
                idx_reg <= '0;
            else if (cmd.step)
                idx_reg <= idx_reg + IW'(1);
            p1_valid_reg <= cmd.step;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
            if (positive)
            begin
                for (int k = DEPTH - 1; k > 0; k--)
                    win_reg[k] <= win_reg[k-1];
                win_reg[0] <= sample;
            end
        end
        if (cmd.step)
            cand_reg <= win_reg[idx_reg];
        cand2_reg <= cand_reg;
        match_reg <= match_next;
        cand3_reg <= cand2_reg;
        cnt_reg   <= cnt_next;
        if (cmd.scan_start)
        begin
            best_val_reg <= '0;
            best_cnt_reg <= '0;
        end
        else if (p3_valid_reg && better)
        begin
            best_val_reg <= cand3_reg;
            best_cnt_reg <= cnt_reg;
        end
        if (cmd.load_out)
        begin
            filtered_reg    <= cmd.use_mode ? ext_mode[OUT_WIDTH-1:0]
                                            : ext_pass[OUT_WIDTH-1:0];
            from_window_reg <= cmd.use_mode;
        end
    end

    // zero extend or truncate to the result width
    assign ext_mode = {{OUT_WIDTH{1'b0}}, best_val_reg};
    assign ext_pass = {{OUT_WIDTH{1'b0}}, sample_reg};

    assign filtered_value = filtered_reg;
    assign from_window    = from_window_reg;

endmodule

FILE: sv/sliding_window_mode_filter.sv
// ----------------------------------------------------------------------------
// sliding_window_mode_filter
// Replaces each reading with the most frequent value among the recently
// stored positive samples, or passes it through while the window fills.
//
//   channel  direction  handshake              payload
//   in       request    in_valid / in_ready    sample
//   out      result     out_valid / out_ready  filtered_value, from_window
//
// A pass-through item goes from idle through check to finish; a window item
// also runs the scan, which counts one candidate entry per cycle against all
// held entries, and drains the count pipeline first. One item is worked on
// at a time; the next request is taken while the previous result waits in
// the output register. Reset empties the window; a stalled output only holds
// the block once a second result is ready.
// ----------------------------------------------------------------------------
module sliding_window_mode_filter #(
    parameter int WINDOW       = 20,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [SAMPLE_WIDTH-1:0]        sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [swmf_pkg::OUT_WIDTH-1:0] filtered_value,
    output logic                           from_window
);
    import swmf_pkg::*;

    cmd_t    cmd;
    status_t status;

    swmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    swmf_datapath #(
        .WINDOW       (WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         (sample),
        .cmd            (cmd),
        .status         (status),
        .filtered_value (filtered_value),
        .from_window    (from_window)
    );

endmodule

FILE: tb/tb_sliding_window_mode_filter.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_mode_filter
// Self-checking bench for the sliding window mode filter. Requests are sent
// over the valid/ready input, a local window model predicts each result, and
// a checker compares every accepted result in order. Directed items cover
// pass-through while filling, non-positive samples and ties between counts;
// random items then repeat a small pool of values so that real modes form.
// ----------------------------------------------------------------------------
module tb_sliding_window_mode_filter;

    import swmf_pkg::*;

    localparam int WINDOW       = 20;
    localparam int SAMPLE_WIDTH = 32;
    localparam int HOLD_MAX     = WINDOW + 1;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 60;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic [SAMPLE_WIDTH-1:0] sample    = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [OUT_WIDTH-1:0]    filtered_value;
    logic                    from_window;

    // model state: held samples, oldest first
    logic signed [SAMPLE_WIDTH-1:0] held_samples[$];

    logic [OUT_WIDTH-1:0] exp_filtered[$];
    logic                 exp_from_window[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int cycle_count   = 0;

    sliding_window_mode_filter #(
        .WINDOW      (WINDOW),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .filtered_value(filtered_value),
        .from_window   (from_window)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sliding_window_mode_filter verification failed");
            $finish;
        end
    end

    // window update and mode search for one accepted request
    task automatic predict_mode(input logic [SAMPLE_WIDTH-1:0] raw);
        logic signed [SAMPLE_WIDTH-1:0] s;
        logic signed [SAMPLE_WIDTH-1:0] best;
        int best_n;
        int n;
        begin
            s = raw;
            if (held_samples.size() > WINDOW)
                void'(held_samples.pop_front());
            if (s > 0 && held_samples.size() < HOLD_MAX)
                held_samples.insert(held_samples.size(), s);
            if (held_samples.size() >= WINDOW)
            begin
                best   = '0;
                best_n = 0;
                foreach (held_samples[i])
                begin
                    n = 0;
                    foreach (held_samples[j])
                        if (held_samples[j] == held_samples[i])
                            n++;
                    // equal counts go to the smaller signed value
                    if (n > best_n || (n == best_n && held_samples[i] < best))
                    begin
                        best   = held_samples[i];
                        best_n = n;
                    end
                end
                exp_filtered.insert(exp_filtered.size(), OUT_WIDTH'(best));
                exp_from_window.insert(exp_from_window.size(), 1'b1);
            end
            else
            begin
                exp_filtered.insert(exp_filtered.size(), OUT_WIDTH'(raw));
                exp_from_window.insert(exp_from_window.size(), 1'b0);
            end
        end
    endtask

    // one request; called just after a rising edge
    task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] v);
        int gap;
        begin
            gap = 0;
            while (gap < 8 && $urandom_range(99) < send_idle_pct)
                gap++;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            sample   <= v;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            predict_mode(v);
        end
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (out_valid && out_ready)
        begin
            if (exp_filtered.size() == 0)
            begin
                $display("%0t: unexpected result filtered_value=%h from_window=%b",
                         $time, filtered_value, from_window);
                error_count++;
            end
            else
            begin
                if (filtered_value !== exp_filtered[0])
                begin
                    $display("%0t: filtered_value expected %h actual %h",
                             $time, exp_filtered[0], filtered_value);
                    error_count++;
                end
                if (from_window !== exp_from_window[0])
                begin
                    $display("%0t: from_window expected %b actual %b",
                             $time, exp_from_window[0], from_window);
                    error_count++;
                end
                void'(exp_filtered.pop_front());
                void'(exp_from_window.pop_front());
            end
        end
    end

    // extremes while the window is still filling, non-positive ones not stored
    task automatic test_pass_through;
        begin
            send_sample(32'h0000_0000);
            send_sample(32'hFFFF_FFFF);
            send_sample(32'h8000_0000);
            send_sample(32'h7FFF_FFFF);
            send_sample(32'h0000_0001);
            send_sample(32'h0000_0100);
        end
    endtask

    // fill to the window size with a tie, then break it, then slide
    task automatic test_window_ties;
        begin
            for (int i = 0; i < 8; i++)
            begin
                send_sample(32'h0000_0500);
                send_sample(32'h0000_0300);
            end
            send_sample(32'h5555_5555);
            send_sample(32'h0000_0500);
            send_sample(32'hAAAA_AAAA);
            send_sample(32'h0000_0300);
        end
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int count);
        logic [SAMPLE_WIDTH-1:0] pool[6];
        logic [SAMPLE_WIDTH-1:0] v;
        int r;
        begin
            send_idle_pct = send_pct;
            recv_idle_pct = recv_pct;
            for (int k = 0; k < count; k++)
            begin
                // fresh small pool now and then so the mode moves around
                if (k % 60 == 0)
                    foreach (pool[p])
                        pool[p] = ($urandom_range(1) == 1) ?
                                  SAMPLE_WIDTH'($urandom_range(1, 8) << 8) :
                                  (($urandom() & 32'h7FFF_FFFF) | 32'h1);
                r = $urandom_range(99);
                if (r < 72)
                    v = pool[$urandom_range(5)];
                else if (r < 82)
                    v = $urandom_range(1, 16);
                else if (r < 94)
                    v = $urandom();
                else if (r < 97)
                    v = '0;
                else
                    v = ($urandom_range(1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                send_sample(v);
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 26;
        recv_idle_pct = 65;
        test_pass_through();
        test_window_ties();
        test_random(26, 65, 400);
        test_random(65, 26, 400);
        test_random(0, 0, 400);
        in_valid <= 1'b0;

        while (exp_filtered.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("sliding_window_mode_filter verification clean");
        else
            $display("sliding_window_mode_filter verification failed");
        $finish;
    end

endmodule

FILE: files.f
sv/swmf_pkg.sv
sv/swmf_ctrl.sv
sv/swmf_datapath.sv
sv/sliding_window_mode_filter.sv
tb/tb_sliding_window_mode_filter.sv
